@@ src/tksd_pkg.sv @@
package tksd_pkg;

  // Sizing
  localparam int SEQ_CAPACITY_DEF = 13;
  localparam int MATCH_LEN        = 6;   // longest table text
  localparam int NSEQ             = 53;
  localparam int CODE_W           = 7;
  localparam int Q_DEPTH          = 2;
  localparam int QPW              = $clog2(Q_DEPTH);
  localparam int QCW              = $clog2(Q_DEPTH + 1);

  // Byte values with special meaning
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_CTRL_Z   = 8'd26;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_O        = 8'h4F;
  localparam logic [7:0] CH_A        = 8'h41;

  // Key codes
  localparam logic [CODE_W-1:0] K_BACK    = 7'd0;
  localparam logic [CODE_W-1:0] K_TAB     = 7'd1;
  localparam logic [CODE_W-1:0] K_ENTER   = 7'd2;
  localparam logic [CODE_W-1:0] K_ESC     = 7'd3;
  localparam logic [CODE_W-1:0] K_C_BASE  = 7'd3;  // C_A sits at base + 1
  localparam logic [CODE_W-1:0] K_F1      = 7'd28;
  localparam logic [CODE_W-1:0] K_F2      = 7'd29;
  localparam logic [CODE_W-1:0] K_F3      = 7'd30;
  localparam logic [CODE_W-1:0] K_F4      = 7'd31;
  localparam logic [CODE_W-1:0] K_F5      = 7'd32;
  localparam logic [CODE_W-1:0] K_F6      = 7'd33;
  localparam logic [CODE_W-1:0] K_F7      = 7'd34;
  localparam logic [CODE_W-1:0] K_F8      = 7'd35;
  localparam logic [CODE_W-1:0] K_F9      = 7'd36;
  localparam logic [CODE_W-1:0] K_F10     = 7'd37;
  localparam logic [CODE_W-1:0] K_F11     = 7'd38;
  localparam logic [CODE_W-1:0] K_F12     = 7'd39;
  localparam logic [CODE_W-1:0] K_SF1     = 7'd40;
  localparam logic [CODE_W-1:0] K_SF2     = 7'd41;
  localparam logic [CODE_W-1:0] K_SF3     = 7'd42;
  localparam logic [CODE_W-1:0] K_SF4     = 7'd43;
  localparam logic [CODE_W-1:0] K_SF5     = 7'd44;
  localparam logic [CODE_W-1:0] K_SF6     = 7'd45;
  localparam logic [CODE_W-1:0] K_SF7     = 7'd46;
  localparam logic [CODE_W-1:0] K_SF8     = 7'd47;
  localparam logic [CODE_W-1:0] K_SF9     = 7'd48;
  localparam logic [CODE_W-1:0] K_SF10    = 7'd49;
  localparam logic [CODE_W-1:0] K_SF11    = 7'd50;
  localparam logic [CODE_W-1:0] K_SF12    = 7'd51;
  localparam logic [CODE_W-1:0] K_UP      = 7'd52;
  localparam logic [CODE_W-1:0] K_DOWN    = 7'd53;
  localparam logic [CODE_W-1:0] K_RIGHT   = 7'd54;
  localparam logic [CODE_W-1:0] K_LEFT    = 7'd55;
  localparam logic [CODE_W-1:0] K_HOME    = 7'd56;
  localparam logic [CODE_W-1:0] K_END     = 7'd57;
  localparam logic [CODE_W-1:0] K_INS     = 7'd58;
  localparam logic [CODE_W-1:0] K_DEL     = 7'd59;
  localparam logic [CODE_W-1:0] K_PGUP    = 7'd60;
  localparam logic [CODE_W-1:0] K_PGDN    = 7'd61;
  localparam logic [CODE_W-1:0] K_C_UP    = 7'd62;
  localparam logic [CODE_W-1:0] K_C_DOWN  = 7'd63;
  localparam logic [CODE_W-1:0] K_C_RIGHT = 7'd64;
  localparam logic [CODE_W-1:0] K_C_LEFT  = 7'd65;
  localparam logic [CODE_W-1:0] K_C_HOME  = 7'd66;
  localparam logic [CODE_W-1:0] K_C_END   = 7'd67;
  localparam logic [CODE_W-1:0] K_C_INS   = 7'd68;
  localparam logic [CODE_W-1:0] K_C_DEL   = 7'd69;
  localparam logic [CODE_W-1:0] K_C_PGUP  = 7'd70;
  localparam logic [CODE_W-1:0] K_C_PGDN  = 7'd71;
  localparam logic [CODE_W-1:0] K_S_TAB   = 7'd72;
  localparam logic [CODE_W-1:0] K_S_ENTER = 7'd73;

  typedef struct packed {
    logic              is_named;
    logic [CODE_W-1:0] key_code;
    logic [7:0]        char_value;
  } key_result_t;

  // Text is right-justified: the first character sits in the highest used byte.
  typedef struct packed {
    logic [8*MATCH_LEN-1:0] text;
    logic [2:0]             len;
    logic [CODE_W-1:0]      code;
  } seq_entry_t;

  localparam seq_entry_t SEQ_TABLE [NSEQ] = '{
    '{"O2P", 3'd3, K_SF1}, '{"O2Q", 3'd3, K_SF2}, '{"O2R", 3'd3, K_SF3},
    '{"O2S", 3'd3, K_SF4}, '{"OM", 3'd2, K_S_ENTER}, '{"OP", 3'd2, K_F1},
    '{"OQ", 3'd2, K_F2}, '{"OR", 3'd2, K_F3}, '{"OS", 3'd2, K_F4},
    '{"[15;2~", 3'd6, K_SF5}, '{"[15~", 3'd4, K_F5},
    '{"[17;2~", 3'd6, K_SF6}, '{"[17~", 3'd4, K_F6},
    '{"[18;2~", 3'd6, K_SF7}, '{"[18~", 3'd4, K_F7},
    '{"[19;2~", 3'd6, K_SF8}, '{"[19~", 3'd4, K_F8},
    '{"[1;5A", 3'd5, K_C_UP}, '{"[1;5B", 3'd5, K_C_DOWN},
    '{"[1;5C", 3'd5, K_C_RIGHT}, '{"[1;5D", 3'd5, K_C_LEFT},
    '{"[1;5F", 3'd5, K_C_END}, '{"[1;5H", 3'd5, K_C_HOME},
    '{"[1~", 3'd3, K_HOME},
    '{"[20;2~", 3'd6, K_SF9}, '{"[20~", 3'd4, K_F9},
    '{"[21;2~", 3'd6, K_SF10}, '{"[21~", 3'd4, K_F10},
    '{"[23;2~", 3'd6, K_SF11}, '{"[23~", 3'd4, K_F11},
    '{"[24;2~", 3'd6, K_SF12}, '{"[24~", 3'd4, K_F12},
    '{"[2;5~", 3'd5, K_C_INS}, '{"[2~", 3'd3, K_INS},
    '{"[3;5~", 3'd5, K_C_DEL}, '{"[3~", 3'd3, K_DEL},
    '{"[4~", 3'd3, K_END},
    '{"[5;5~", 3'd5, K_C_PGUP}, '{"[5~", 3'd3, K_PGUP},
    '{"[6;5~", 3'd5, K_C_PGDN}, '{"[6~", 3'd3, K_PGDN},
    '{"[A", 3'd2, K_UP}, '{"[B", 3'd2, K_DOWN}, '{"[C", 3'd2, K_RIGHT},
    '{"[D", 3'd2, K_LEFT}, '{"[F", 3'd2, K_END}, '{"[H", 3'd2, K_HOME},
    '{"[Z", 3'd2, K_S_TAB},
    '{"[[A", 3'd3, K_F1}, '{"[[B", 3'd3, K_F2}, '{"[[C", 3'd3, K_F3},
    '{"[[D", 3'd3, K_F4}, '{"[[E", 3'd3, K_F5}
  };

  // Character i of a table entry, counted from the start of its text.
  function automatic logic [7:0] entry_byte(seq_entry_t ent, int i);
    int sh;
    sh = int'(ent.len) - 1 - i;
    if (sh < 0) begin
      return 8'd0;
    end
    return ent.text[8*sh +: 8];
  endfunction

endpackage

@@ src/tksd_if.sv @@
interface tksd_byte_if ();
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

interface tksd_key_if import tksd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_named;
  logic [CODE_W-1:0] key_code;
  logic [7:0]        char_value;
  logic              last;

  modport source (output valid, output is_named, output key_code, output char_value,
                  output last, input ready);
  modport sink   (input valid, input is_named, input key_code, input char_value,
                  input last, output ready);
endinterface

@@ src/terminal_key_sequence_decoder_core.sv @@
// Path: byte beat -> input register -> decode -> result queue -> key port.
// Throughput: one byte beat per cycle while the result queue has room; a byte that
//   yields ESC plus a second key holds its result queue entry for two key beats, set
//   by the single key port.
// Reset (rst, synchronous): closes any open sequence and empties the input stage
//   and the two-entry result queue; the sequence byte buffer is not cleared.
module terminal_key_sequence_decoder_core import tksd_pkg::*; #(
  parameter int SEQ_CAPACITY = SEQ_CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tksd_byte_if.sink    bytes,
  tksd_key_if.source   keys
);

  // pos: 0 idle, 1 ESC seen, p >= 2 means p-1 bytes held; saturates at capacity+1
  localparam int PW = $clog2(SEQ_CAPACITY + 2);
  localparam int IW = $clog2(SEQ_CAPACITY);

  typedef struct packed {
    logic        hit;    // a key comes out
    logic        opens;  // byte was ESC
    key_result_t res;
  } plain_t;

  typedef struct packed {
    logic        two;    // ESC in r0, second key in r1
    key_result_t r0;
    key_result_t r1;
  } q_entry_t;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       in_fire;

  // ---------------------------------------------------------------------------
  // Sequence state
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    seq_buffer [SEQ_CAPACITY];
  logic          buf_we;
  logic [IW-1:0] buf_idx;

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  q_entry_t       q [Q_DEPTH];
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           sub;        // which beat of the head entry is on the port
  logic           push, pop, beat_last;
  q_entry_t       new_entry;
  key_result_t    cur;

  // Decode logic
  logic          idle;
  logic [1:0]    n_res;
  key_result_t   res_a, res_b;
  plain_t        plain;
  logic          final_byte;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] match_len;
  logic [7:0]    cand [MATCH_LEN];
  logic          m_hit;
  logic [CODE_W-1:0] m_code;

  // Byte decode with no sequence open
  function automatic plain_t decode_plain(logic [7:0] ch);
    plain_t p;
    logic [CODE_W-1:0] c;
    p = '0;
    c = K_C_BASE + {{(CODE_W-5){1'b0}}, ch[4:0]};
    if (ch > CH_TAB) begin
      c = c - 7'd1;
    end
    if (ch > CH_CR) begin
      c = c - 7'd1;
    end
    if (ch == CH_DEL) begin
      p.hit = 1'b1;
      p.res.is_named = 1'b1;
      p.res.key_code = K_BACK;
    end else if (ch >= CH_SPACE) begin
      p.hit = 1'b1;
      p.res.char_value = ch;
    end else if (ch == CH_TAB) begin
      p.hit = 1'b1;
      p.res.is_named = 1'b1;
      p.res.key_code = K_TAB;
    end else if (ch == CH_CR) begin
      p.hit = 1'b1;
      p.res.is_named = 1'b1;
      p.res.key_code = K_ENTER;
    end else if (ch != 8'd0 && ch <= CH_CTRL_Z) begin
      p.hit = 1'b1;
      p.res.is_named = 1'b1;
      p.res.key_code = c;
    end else if (ch == CH_ESC) begin
      p.opens = 1'b1;
    end
    return p;
  endfunction

  assign idle       = s1_cmd || (s1_byte == 8'd0);
  assign plain      = decode_plain(s1_byte);
  assign final_byte = (s1_byte >= CH_A) && (s1_byte != CH_LBRACKET);
  assign pos_m1     = pos - PW'(1);
  assign buf_idx    = pos_m1[IW-1:0];
  assign match_len  = (pos <= PW'(SEQ_CAPACITY)) ? pos : PW'(SEQ_CAPACITY);

  // Text as it stands once this byte is stored; the new byte lands at pos-1.
  always_comb begin
    for (int i = 0; i < MATCH_LEN; i++) begin
      cand[i] = (pos == PW'(i + 1)) ? s1_byte : seq_buffer[i];
    end
  end

  // Parallel exact match against the table; entries are distinct.
  always_comb begin
    logic h;
    m_hit  = 1'b0;
    m_code = '0;
    for (int e = 0; e < NSEQ; e++) begin
      h = (match_len == PW'(SEQ_TABLE[e].len));
      for (int i = 0; i < MATCH_LEN; i++) begin
        if (i < int'(SEQ_TABLE[e].len) && entry_byte(SEQ_TABLE[e], i) != cand[i]) begin
          h = 1'b0;
        end
      end
      if (h) begin
        m_hit  = 1'b1;
        m_code = m_code | SEQ_TABLE[e].code;
      end
    end
  end

  // Step of the decoder for the byte in the input register
  always_comb begin
    key_result_t esc;
    esc          = '0;
    esc.is_named = 1'b1;
    esc.key_code = K_ESC;
    n_res    = 2'd0;
    res_a    = '0;
    res_b    = '0;
    pos_next = pos;
    buf_we   = 1'b0;
    if (idle) begin
      if (pos == PW'(1)) begin
        n_res    = 2'd1;
        res_a    = esc;
        pos_next = '0;
      end
    end else if (pos == '0) begin
      n_res = {1'b0, plain.hit};
      res_a = plain.res;
      if (plain.opens) begin
        pos_next = PW'(1);
      end
    end else if (pos == PW'(1)) begin
      if (s1_byte != CH_LBRACKET && s1_byte != CH_O) begin
        // lone ESC, then this byte decoded from scratch
        n_res    = plain.hit ? 2'd2 : 2'd1;
        res_a    = esc;
        res_b    = plain.res;
        pos_next = plain.opens ? PW'(1) : '0;
      end else begin
        buf_we   = 1'b1;
        pos_next = PW'(2);
      end
    end else begin
      if (pos <= PW'(SEQ_CAPACITY)) begin
        buf_we   = 1'b1;
        pos_next = pos + PW'(1);
      end
      if (final_byte) begin
        pos_next = '0;
        if (m_hit) begin
          n_res          = 2'd1;
          res_a.is_named = 1'b1;
          res_a.key_code = m_code;
        end
      end
    end
  end

  // Input stage moves on when the queue has room for a whole entry.
  assign s1_adv      = s1_valid && (count < QCW'(Q_DEPTH));
  assign bytes.ready = !s1_valid || s1_adv;
  assign in_fire     = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd  <= bytes.cmd;
      s1_byte <= bytes.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (s1_adv) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && buf_we) begin
      seq_buffer[buf_idx] <= s1_byte;
    end
  end

  // Result queue: one entry per byte that yields anything
  assign new_entry.two = (n_res == 2'd2);
  assign new_entry.r0  = res_a;
  assign new_entry.r1  = res_b;
  assign push          = s1_adv && (n_res != 2'd0);

  assign cur       = sub ? q[rd_ptr].r1 : q[rd_ptr].r0;
  assign beat_last = sub || !q[rd_ptr].two;
  assign pop       = keys.valid && keys.ready && beat_last;

  assign keys.valid      = (count != '0);
  assign keys.is_named   = cur.is_named;
  assign keys.key_code   = cur.key_code;
  assign keys.char_value = cur.char_value;
  assign keys.last       = beat_last;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
        sub    <= 1'b0;
      end else if (keys.valid && keys.ready) begin
        sub <= 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/tksd_checker.sv @@
module tksd_checker import tksd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              keys_valid,
  input logic              keys_ready,
  input logic              keys_is_named,
  input logic [CODE_W-1:0] keys_key_code,
  input logic [7:0]        keys_char_value,
  input logic              keys_last
);

  // Stalled key beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    keys_valid && !keys_ready |=> keys_valid && $stable(keys_is_named) &&
      $stable(keys_key_code) && $stable(keys_char_value) && $stable(keys_last))
    else $error("stalled key beat changed");

  // Nothing on the key port right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !keys_valid)
    else $error("key beat right after reset");

  // Only a lone ESC is ever followed by a second key
  a_first_esc: assert property (@(posedge clk) disable iff (rst)
    keys_valid && !keys_last |-> keys_is_named && keys_key_code == K_ESC)
    else $error("non-final key beat is not ESC");

  // Second key of a pair is ready at once and closes the byte
  a_pair: assert property (@(posedge clk) disable iff (rst)
    keys_valid && keys_ready && !keys_last |=> keys_valid && keys_last)
    else $error("second key of a pair missing");

  // Field consistency
  a_fields: assert property (@(posedge clk) disable iff (rst)
    keys_valid |-> (keys_is_named && keys_char_value == 8'd0 && keys_key_code <= K_S_ENTER) ||
      (!keys_is_named && keys_key_code == '0 && keys_char_value >= CH_SPACE))
    else $error("inconsistent key beat fields");

endmodule

bind terminal_key_sequence_decoder_core tksd_checker u_tksd_checker (
  .clk             (clk),
  .rst             (rst),
  .keys_valid      (keys.valid),
  .keys_ready      (keys.ready),
  .keys_is_named   (keys.is_named),
  .keys_key_code   (keys.key_code),
  .keys_char_value (keys.char_value),
  .keys_last       (keys.last)
);

@@ tb/terminal_key_sequence_decoder_core_tb.sv @@
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_core_tb;
  import tksd_pkg::*;

  // Byte channel command: a received byte, or an idle tick with no byte available
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } byte_cmd_e;

  typedef struct {
    logic              is_named;
    logic [CODE_W-1:0] key_code;
    logic [7:0]        char_value;
    logic              last;
  } key_beat_t;

  localparam int SEQ_CAP  = SEQ_CAPACITY_DEF;
  localparam int NUM_SEQS = 53;

  // Decoder position: nothing open, ESC just seen, or (2 and up) bytes being held
  localparam int SEQ_NONE = 0;
  localparam int SEQ_ESC  = 1;

  // Known key sequences (text after ESC) and the key each one gives
  string key_seq_text [NUM_SEQS] = '{
    "O2P", "O2Q", "O2R", "O2S", "OM", "OP", "OQ", "OR", "OS",
    "[15;2~", "[15~", "[17;2~", "[17~", "[18;2~", "[18~", "[19;2~", "[19~",
    "[1;5A", "[1;5B", "[1;5C", "[1;5D", "[1;5F", "[1;5H", "[1~",
    "[20;2~", "[20~", "[21;2~", "[21~", "[23;2~", "[23~", "[24;2~", "[24~",
    "[2;5~", "[2~", "[3;5~", "[3~", "[4~", "[5;5~", "[5~", "[6;5~", "[6~",
    "[A", "[B", "[C", "[D", "[F", "[H", "[Z",
    "[[A", "[[B", "[[C", "[[D", "[[E"
  };
  logic [CODE_W-1:0] key_seq_code [NUM_SEQS] = '{
    K_SF1, K_SF2, K_SF3, K_SF4, K_S_ENTER, K_F1, K_F2, K_F3, K_F4,
    K_SF5, K_F5, K_SF6, K_F6, K_SF7, K_F7, K_SF8, K_F8,
    K_C_UP, K_C_DOWN, K_C_RIGHT, K_C_LEFT, K_C_END, K_C_HOME, K_HOME,
    K_SF9, K_F9, K_SF10, K_F10, K_SF11, K_F11, K_SF12, K_F12,
    K_C_INS, K_INS, K_C_DEL, K_DEL, K_END, K_C_PGUP, K_PGUP, K_C_PGDN, K_PGDN,
    K_UP, K_DOWN, K_RIGHT, K_LEFT, K_END, K_HOME, K_S_TAB,
    K_F1, K_F2, K_F3, K_F4, K_F5
  };

  logic clk;
  logic rst;

  tksd_byte_if byte_bus ();
  tksd_key_if  key_bus ();

  terminal_key_sequence_decoder_core dut (
    .clk  (clk),
    .rst  (rst),
    .bytes(byte_bus),
    .keys (key_bus)
  );

  // Decoder state as predicted
  int         seq_pos;
  logic [7:0] held_bytes [SEQ_CAP];

  key_beat_t  expected_keys [$];   // key beats still owed by the DUT, oldest first
  key_beat_t  step_keys [$];       // keys produced by the byte beat being predicted

  int mismatch_count;
  int sent_beats;
  int sender_idle_pct;
  int receiver_stall_pct;

  // ---------------------------------------------------------------------------
  // Clock, timeout, receiver ready
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Sink side: ready drops at random with the current stall rate
  initial begin
    key_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      key_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatch_count < 30) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Key decoder prediction
  // ---------------------------------------------------------------------------
  task automatic add_key(input logic named, input logic [CODE_W-1:0] code,
                         input logic [7:0] chr);
    key_beat_t k;
    k.is_named   = named;
    k.key_code   = code;
    k.char_value = chr;
    k.last       = 1'b0;
    step_keys.push_back(k);
  endtask

  // Byte with no sequence open
  task automatic decode_plain_byte(input logic [7:0] ch);
    int code;
    if (ch == CH_DEL) begin
      add_key(1'b1, K_BACK, 8'd0);
    end else if (ch >= CH_SPACE) begin
      add_key(1'b0, '0, ch);
    end else if (ch == CH_TAB) begin
      add_key(1'b1, K_TAB, 8'd0);
    end else if (ch == CH_CR) begin
      add_key(1'b1, K_ENTER, 8'd0);
    end else if (ch >= 8'd1 && ch <= CH_CTRL_Z) begin
      // control letters are packed densely, skipping the TAB and CR slots
      code = int'(K_C_BASE) + int'(ch) - (ch > CH_TAB ? 1 : 0) - (ch > CH_CR ? 1 : 0);
      add_key(1'b1, CODE_W'(code), 8'd0);
    end else if (ch == CH_ESC) begin
      seq_pos = SEQ_ESC;
    end
    // 28..31 are dropped
  endtask

  // Key for the held sequence text, or -1 if no known sequence matches it
  function automatic int match_held_text(input int len);
    bool_loop: for (int e = 0; e < NUM_SEQS; e++) begin
      if (key_seq_text[e].len() == len) begin
        int same;
        same = 1;
        for (int i = 0; i < len; i++) begin
          if (key_seq_text[e][i] != held_bytes[i]) begin
            same = 0;
          end
        end
        if (same != 0) begin
          return int'(key_seq_code[e]);
        end
      end
    end
    return -1;
  endfunction

  task automatic predict_keys(input byte_cmd_e cmd, input logic [7:0] ch);
    int code;
    step_keys.delete();
    if (cmd == CMD_IDLE || ch == 8'd0) begin
      // an idle tick only matters right after ESC: ESC stands alone
      if (seq_pos == SEQ_ESC) begin
        seq_pos = SEQ_NONE;
        add_key(1'b1, K_ESC, 8'd0);
      end
    end else if (seq_pos == SEQ_NONE) begin
      decode_plain_byte(ch);
    end else if (seq_pos == SEQ_ESC) begin
      if (ch != CH_LBRACKET && ch != CH_O) begin
        seq_pos = SEQ_NONE;
        add_key(1'b1, K_ESC, 8'd0);
        decode_plain_byte(ch);
      end else begin
        held_bytes[0] = ch;
        seq_pos       = 2;
      end
    end else begin
      // past capacity nothing more is held, the final byte included
      if (seq_pos <= SEQ_CAP) begin
        held_bytes[seq_pos - 1] = ch;
        seq_pos++;
      end
      if (ch >= CH_A && ch != CH_LBRACKET) begin
        code    = match_held_text(seq_pos - 1);
        seq_pos = SEQ_NONE;
        if (code >= 0) begin
          add_key(1'b1, CODE_W'(code), 8'd0);
        end
      end
    end
    if (step_keys.size() > 0) begin
      step_keys[step_keys.size() - 1].last = 1'b1;
    end
    foreach (step_keys[i]) begin
      expected_keys.push_back(step_keys[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Key beat checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : key_check
    key_beat_t want;
    if (!rst && key_bus.valid === 1'b1 && key_bus.ready === 1'b1) begin
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("key beat with none pending (named %0b code %0d char %0d)",
                                  key_bus.is_named, key_bus.key_code, key_bus.char_value));
      end else begin
        want = expected_keys.pop_front();
        if (key_bus.is_named !== want.is_named) begin
          report_mismatch($sformatf("is_named %0b, want %0b", key_bus.is_named,
                                    want.is_named));
        end
        if (key_bus.key_code !== want.key_code) begin
          report_mismatch($sformatf("key_code %0d, want %0d", key_bus.key_code,
                                    want.key_code));
        end
        if (key_bus.char_value !== want.char_value) begin
          report_mismatch($sformatf("char_value %0d, want %0d", key_bus.char_value,
                                    want.char_value));
        end
        if (key_bus.last !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", key_bus.last, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte beat driver
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge that accepted the beat.
  task automatic send_beat(input byte_cmd_e cmd, input logic [7:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_bus.valid <= 1'b0;
      byte_bus.cmd        <= 1'($urandom_range(1));
      byte_bus.byte_value <= 8'($urandom_range(255));
      @(posedge clk);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.cmd        <= cmd;
    byte_bus.byte_value <= value;
    do @(posedge clk); while (byte_bus.ready !== 1'b1);
    predict_keys(cmd, value);
    sent_beats++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_beat(CMD_BYTE, txt[i]);
    end
  endtask

  // Idle tick or zero byte, both act the same
  task automatic send_gap_beat();
    if ($urandom_range(1) == 0) begin
      send_beat(CMD_IDLE, 8'($urandom_range(255)));
    end else begin
      send_beat(CMD_BYTE, 8'd0);
    end
  endtask

  // Hold off until every owed key beat has come back; returns on a later edge
  task automatic wait_drained();
    byte_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Plain bytes at the range edges and every class of byte but ESC
  task automatic test_plain_bytes();
    send_beat(CMD_BYTE, 8'd0);
    send_beat(CMD_BYTE, 8'd255);
    send_beat(CMD_BYTE, CH_SPACE);
    send_beat(CMD_BYTE, CH_DEL);
    send_beat(CMD_BYTE, CH_TAB);
    send_beat(CMD_BYTE, CH_CR);
    send_beat(CMD_BYTE, 8'd1);
    send_beat(CMD_BYTE, CH_CTRL_Z);
    send_beat(CMD_BYTE, 8'd28);
    send_beat(CMD_BYTE, 8'd31);
    send_beat(CMD_IDLE, 8'd255);
  endtask

  // ESC followed by idle, zero, a foreign byte and another ESC; gaps mid-sequence
  task automatic test_escape_handling();
    send_beat(CMD_BYTE, CH_ESC);
    send_beat(CMD_IDLE, 8'd0);
    send_beat(CMD_BYTE, CH_ESC);
    send_beat(CMD_BYTE, 8'd0);
    send_beat(CMD_BYTE, CH_ESC);
    send_beat(CMD_BYTE, "x");
    send_beat(CMD_BYTE, CH_ESC);
    send_beat(CMD_BYTE, CH_ESC);
    send_beat(CMD_BYTE, CH_LBRACKET);
    send_beat(CMD_IDLE, 8'h5A);
    send_beat(CMD_BYTE, 8'd0);
    send_beat(CMD_BYTE, "A");
    // high byte ends a sequence, no match
    send_beat(CMD_BYTE, CH_ESC);
    send_text("[1");
    send_beat(CMD_BYTE, 8'd200);
  endtask

  // Every known sequence once; overflow past capacity once
  task automatic test_table_keys();
    for (int e = 0; e < NUM_SEQS; e++) begin
      send_beat(CMD_BYTE, CH_ESC);
      send_text(key_seq_text[e]);
    end
    send_beat(CMD_BYTE, CH_ESC);
    send_text("[1234567890;2345~");
  endtask

  task automatic random_event();
    int         pick;
    int         e;
    int         cut;
    int         n;
    string      txt;
    logic [7:0] v;
    pick = $urandom_range(99);
    e    = $urandom_range(NUM_SEQS - 1);
    txt  = key_seq_text[e];
    if (pick < 45) begin
      // well-formed sequence, sometimes with an idle tick or zero byte inside
      cut = ($urandom_range(3) == 0) ? $urandom_range(1, txt.len() - 1) : -1;
      send_beat(CMD_BYTE, CH_ESC);
      for (int i = 0; i < txt.len(); i++) begin
        if (i == cut) begin
          send_gap_beat();
        end
        send_beat(CMD_BYTE, txt[i]);
      end
    end else if (pick < 55) begin
      // broken sequence: one byte swapped, or cut short and ended at random
      send_beat(CMD_BYTE, CH_ESC);
      if ($urandom_range(1) == 0) begin
        cut = $urandom_range(txt.len() - 1);
        for (int i = 0; i < txt.len(); i++) begin
          v = (i == cut) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'(txt[i]);
          send_beat(CMD_BYTE, v);
        end
      end else begin
        n = $urandom_range(1, txt.len() - 1);
        for (int i = 0; i < n; i++) begin
          send_beat(CMD_BYTE, txt[i]);
        end
        send_beat(CMD_BYTE, 8'($urandom_range(CH_A, 255)));
      end
    end else if (pick < 60) begin
      // long parameter string, often past capacity
      send_beat(CMD_BYTE, CH_ESC);
      send_beat(CMD_BYTE, CH_LBRACKET);
      n = $urandom_range(2, 16);
      for (int i = 0; i < n; i++) begin
        v = ($urandom_range(4) == 0) ? 8'h3B : 8'($urandom_range(8'h30, 8'h39));
        send_beat(CMD_BYTE, v);
      end
      send_beat(CMD_BYTE, 8'($urandom_range(CH_A, 255)));
    end else if (pick < 68) begin
      // ESC then anything
      send_beat(CMD_BYTE, CH_ESC);
      if ($urandom_range(3) == 0) begin
        send_gap_beat();
      end else begin
        send_beat(CMD_BYTE, 8'($urandom_range(255)));
      end
    end else if (pick < 92) begin
      send_beat(CMD_BYTE, 8'($urandom_range(1, 255)));
    end else begin
      send_gap_beat();
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int beats);
    int start;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    start              = sent_beats;
    while (sent_beats - start < beats) begin
      random_event();
    end
    // drain fully before the next phase
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count      = 0;
    sent_beats          = 0;
    sender_idle_pct     = 0;
    receiver_stall_pct  = 0;
    seq_pos             = SEQ_NONE;
    rst                 <= 1'b1;
    byte_bus.valid      <= 1'b0;
    byte_bus.cmd        <= CMD_BYTE;
    byte_bus.byte_value <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_bytes();
    test_escape_handling();
    wait_drained();

    sender_idle_pct    = 26;
    receiver_stall_pct = 26;
    test_table_keys();
    wait_drained();

    test_random_traffic(0, 0, 350);
    test_random_traffic(65, 0, 350);
    test_random_traffic(0, 65, 350);
    test_random_traffic(26, 26, 350);

    // let any stray key beat surface
    repeat (10) @(posedge clk);
    if (expected_keys.size() != 0) begin
      report_mismatch($sformatf("%0d key beats never arrived", expected_keys.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
